@@ rtl/hmmf_pkg.sv @@
// Shared types, constants and filter arithmetic for the 3x3 hybrid median/mean filter.
package hmmf_pkg;

    localparam int MAX_ROW_LENGTH   = 4096;
    localparam int ROW_LEN_W        = 13;
    localparam int COL_W            = $clog2(MAX_ROW_LENGTH);
    localparam int EFF_W            = COL_W + 1;
    localparam int FILL_W           = 4;
    localparam int CHAN_W           = 8;
    localparam int ACC_W            = 12;
    localparam int WIN_SIZE         = 9;
    localparam int WIN_CENTER       = 4;
    localparam int FULL_LOAD_LAST   = 8;
    localparam int COL_LOAD_LAST    = 2;
    localparam int DIV10_RECIP_W    = 13;
    localparam int DIV10_SHIFT      = 16;
    localparam int ACC_MAX          = 2550;

    localparam logic [ROW_LEN_W-1:0]     ROW_LENGTH_RESET = ROW_LEN_W'(256);
    localparam logic [DIV10_RECIP_W-1:0] DIV10_RECIP      = DIV10_RECIP_W'(6554);

    typedef struct packed {
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
    } pixel_t;

    typedef pixel_t [WIN_SIZE-1:0] window_t;
    typedef logic [WIN_SIZE-1:0][CHAN_W-1:0] chan9_t;

    // Median of nine through the classic 19 compare-exchange network.
    function automatic logic [CHAN_W-1:0] median9(input chan9_t v);
        chan9_t p;
        p = v;
        if (p[1] > p[2]) {p[1], p[2]} = {p[2], p[1]};
        if (p[4] > p[5]) {p[4], p[5]} = {p[5], p[4]};
        if (p[7] > p[8]) {p[7], p[8]} = {p[8], p[7]};
        if (p[0] > p[1]) {p[0], p[1]} = {p[1], p[0]};
        if (p[3] > p[4]) {p[3], p[4]} = {p[4], p[3]};
        if (p[6] > p[7]) {p[6], p[7]} = {p[7], p[6]};
        if (p[1] > p[2]) {p[1], p[2]} = {p[2], p[1]};
        if (p[4] > p[5]) {p[4], p[5]} = {p[5], p[4]};
        if (p[7] > p[8]) {p[7], p[8]} = {p[8], p[7]};
        if (p[0] > p[3]) {p[0], p[3]} = {p[3], p[0]};
        if (p[5] > p[8]) {p[5], p[8]} = {p[8], p[5]};
        if (p[4] > p[7]) {p[4], p[7]} = {p[7], p[4]};
        if (p[3] > p[6]) {p[3], p[6]} = {p[6], p[3]};
        if (p[1] > p[4]) {p[1], p[4]} = {p[4], p[1]};
        if (p[2] > p[5]) {p[2], p[5]} = {p[5], p[2]};
        if (p[4] > p[7]) {p[4], p[7]} = {p[7], p[4]};
        if (p[4] > p[2]) {p[4], p[2]} = {p[2], p[4]};
        if (p[6] > p[4]) {p[6], p[4]} = {p[4], p[6]};
        if (p[4] > p[2]) {p[4], p[2]} = {p[2], p[4]};
        return p[WIN_CENTER];
    endfunction

    // Sum of the eight outer pixels plus twice the median; at most 2550.
    function automatic logic [ACC_W-1:0] chan_acc(input chan9_t v);
        logic [ACC_W-1:0] sum;
        sum = '0;
        for (int i = 0; i < WIN_SIZE; i++)
        begin
            if (i != WIN_CENTER)
            begin
                sum = sum + ACC_W'(v[i]);
            end
        end
        return sum + ACC_W'({median9(v), 1'b0});
    endfunction

    // Truncating division by ten, exact for every value below 2560.
    function automatic logic [CHAN_W-1:0] div10(input logic [ACC_W-1:0] x);
        logic [ACC_W+DIV10_RECIP_W-1:0] prod;
        prod = (ACC_W+DIV10_RECIP_W)'(x) * (ACC_W+DIV10_RECIP_W)'(DIV10_RECIP);
        return prod[DIV10_SHIFT +: CHAN_W];
    endfunction

endpackage

@@ rtl/hmmf_in_if.sv @@
// Pixel input channel: valid/ready handshake with one RGB pixel.
interface hmmf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source(output valid, output red, output green, output blue, input ready);
    modport sink(input valid, input red, input green, input blue, output ready);
endinterface

@@ rtl/hmmf_out_if.sv @@
// Filtered result channel: valid/ready handshake with one RGB result.
interface hmmf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;

    modport source(output valid, output out_red, output out_green, output out_blue,
                   input ready);
    modport sink(input valid, input out_red, input out_green, input out_blue,
                 output ready);
endinterface

@@ rtl/hmmf_window.sv @@
// Window loader: fills and slides the 3x3 window and hands complete windows on.
module hmmf_window
    import hmmf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [EFF_W-1:0] eff_len,
    hmmf_in_if.sink          pix_in,
    output logic             snap_valid,
    input  logic             snap_ready,
    output window_t          snap
);

    window_t           window_reg;
    window_t           window_next;
    window_t           win_wr;
    window_t           snap_reg;
    logic              snap_valid_reg;
    logic              snap_valid_next;
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic [FILL_W-1:0] fill_eff;
    logic [FILL_W-1:0] wr_idx;
    logic [COL_W-1:0]  col_reg;
    logic [COL_W-1:0]  col_next;
    logic              full_mode;
    logic              complete;
    logic              row_end;
    logic              accept;
    pixel_t            pix;

    assign pix.red   = pix_in.red;
    assign pix.green = pix_in.green;
    assign pix.blue  = pix_in.blue;

    assign pix_in.ready = !snap_valid_reg || snap_ready;
    assign accept       = pix_in.valid && pix_in.ready;

    assign full_mode = (col_reg == '0);
    assign row_end   = (EFF_W'(col_reg) + EFF_W'(1)) >= eff_len;

    always_comb
    begin
        if (full_mode)
        begin
            fill_eff = (fill_reg > FILL_W'(FULL_LOAD_LAST)) ? '0 : fill_reg;
            wr_idx   = fill_eff;
            complete = (fill_eff == FILL_W'(FULL_LOAD_LAST));
        end
        else
        begin
            fill_eff = (fill_reg > FILL_W'(COL_LOAD_LAST)) ? '0 : fill_reg;
            wr_idx   = FILL_W'(fill_eff * FILL_W'(3) + FILL_W'(2));
            complete = (fill_eff == FILL_W'(COL_LOAD_LAST));
        end

        win_wr         = window_reg;
        win_wr[wr_idx] = pix;

        window_next     = window_reg;
        fill_next       = fill_reg;
        col_next        = col_reg;
        snap_valid_next = snap_valid_reg && !snap_ready;

        if (accept)
        begin
            window_next = win_wr;
            if (complete)
            begin
                fill_next       = '0;
                snap_valid_next = 1'b1;
                if (row_end)
                begin
                    col_next = '0;
                end
                else
                begin
                    col_next = col_reg + COL_W'(1);
                    for (int r = 0; r < 3; r++)
                    begin
                        window_next[3*r]     = win_wr[3*r+1];
                        window_next[3*r + 1] = win_wr[3*r+2];
                    end
                end
            end
            else
            begin
                fill_next = fill_eff + FILL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg       <= '0;
            col_reg        <= '0;
            snap_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg       <= fill_next;
            col_reg        <= col_next;
            snap_valid_reg <= snap_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        window_reg <= window_next;
        if (accept && complete)
        begin
            snap_reg <= win_wr;
        end
    end

    assign snap_valid = snap_valid_reg;
    assign snap       = snap_reg;

`ifndef NO_ASSERTIONS
    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(FULL_LOAD_LAST))
        else $error("fill position left the window");

    a_col_fill: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg != '0 |-> fill_reg <= FILL_W'(COL_LOAD_LAST))
        else $error("column load position out of range");

    a_snap_hold: assert property (@(posedge clk) disable iff (!rst_n)
        snap_valid_reg && !snap_ready |=> snap_valid_reg && $stable(snap_reg))
        else $error("pending window lost or changed while stalled");
`endif

endmodule

@@ rtl/hmmf_calc.sv @@
// Filter arithmetic: median and sum per channel, then division by ten.
module hmmf_calc
    import hmmf_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    snap_valid,
    output logic    snap_ready,
    input  window_t snap,
    hmmf_out_if.source pix_out
);

    chan9_t            red_v;
    chan9_t            green_v;
    chan9_t            blue_v;
    logic [ACC_W-1:0]  acc_red_reg;
    logic [ACC_W-1:0]  acc_green_reg;
    logic [ACC_W-1:0]  acc_blue_reg;
    logic              acc_valid_reg;
    logic              acc_ready;
    logic              out_valid_reg;
    logic              out_ready;
    logic [CHAN_W-1:0] out_red_reg;
    logic [CHAN_W-1:0] out_green_reg;
    logic [CHAN_W-1:0] out_blue_reg;

    always_comb
    begin
        for (int i = 0; i < WIN_SIZE; i++)
        begin
            red_v[i]   = snap[i].red;
            green_v[i] = snap[i].green;
            blue_v[i]  = snap[i].blue;
        end
    end

    assign out_ready  = !out_valid_reg || pix_out.ready;
    assign acc_ready  = !acc_valid_reg || out_ready;
    assign snap_ready = acc_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (acc_ready)
            begin
                acc_valid_reg <= snap_valid;
            end
            if (out_ready)
            begin
                out_valid_reg <= acc_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc_ready && snap_valid)
        begin
            acc_red_reg   <= chan_acc(red_v);
            acc_green_reg <= chan_acc(green_v);
            acc_blue_reg  <= chan_acc(blue_v);
        end
        if (out_ready && acc_valid_reg)
        begin
            out_red_reg   <= div10(acc_red_reg);
            out_green_reg <= div10(acc_green_reg);
            out_blue_reg  <= div10(acc_blue_reg);
        end
    end

    assign pix_out.valid     = out_valid_reg;
    assign pix_out.out_red   = out_red_reg;
    assign pix_out.out_green = out_green_reg;
    assign pix_out.out_blue  = out_blue_reg;

`ifndef NO_ASSERTIONS
    a_acc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        acc_valid_reg |-> acc_red_reg <= ACC_W'(ACC_MAX) && acc_green_reg <= ACC_W'(ACC_MAX)
                          && acc_blue_reg <= ACC_W'(ACC_MAX))
        else $error("channel accumulator above its bound");

    a_acc_hold: assert property (@(posedge clk) disable iff (!rst_n)
        acc_valid_reg && !out_ready |=> acc_valid_reg && $stable(acc_red_reg))
        else $error("accumulator stage changed while stalled");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !pix_out.ready |=> out_valid_reg
            && $stable({out_red_reg, out_green_reg, out_blue_reg}))
        else $error("result changed or dropped while stalled");
`endif

endmodule

@@ rtl/hybrid_median_mean_filter_3x3.sv @@
// Top level of the 3x3 hybrid median/mean RGB filter.
//
//   Channel    Direction  Handshake              Transfer contents
//   pix_in     in         pix_in.valid/ready     red, green, blue of one pixel
//   pix_out    out        pix_out.valid/ready    out_red, out_green, out_blue
//   cfg        in         cfg_write_en           row_length (13 bits)
//
// One pixel transfer can be taken in every cycle unless the pipeline is stalled;
// the loader, the accumulator stage and the output register each hold one window,
// so pixels keep flowing while a result waits at the output until the stages fill.
// A result passes from the pixel transfer that completes its window through the
// loader snapshot, the median/sum register and the divide register.
// Reset clears the fill position, the column count and all valid flags and sets
// row_length to 256; the window contents need no reset because a full nine-pixel
// load always follows reset.
// A stall at pix_out backs up stage by stage and only then drops pix_in.ready.
module hybrid_median_mean_filter_3x3
    import hmmf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write_en,
    input  logic [ROW_LEN_W-1:0] cfg_write_data,
    hmmf_in_if.sink              pix_in,
    hmmf_out_if.source           pix_out
);

    logic [ROW_LEN_W-1:0] row_length_reg;
    logic [EFF_W-1:0]     eff_len;
    logic                 snap_valid;
    logic                 snap_ready;
    window_t              snap;

    // The user must write row_length_reg only while the filter is idle; not enforced.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_length_reg <= ROW_LENGTH_RESET;
        end
        else if (cfg_write_en)
        begin
            row_length_reg <= cfg_write_data;
        end
    end

    // A zero length, or one above the largest supported row, runs as the largest row.
    always_comb
    begin
        if (row_length_reg == '0 || 32'(row_length_reg) > MAX_ROW_LENGTH)
        begin
            eff_len = EFF_W'(MAX_ROW_LENGTH);
        end
        else
        begin
            eff_len = EFF_W'(row_length_reg);
        end
    end

    // Loader: collects nine pixels at a row start and three per column after that.
    hmmf_window u_window (
        .clk        (clk),
        .rst_n      (rst_n),
        .eff_len    (eff_len),
        .pix_in     (pix_in),
        .snap_valid (snap_valid),
        .snap_ready (snap_ready),
        .snap       (snap)
    );

    // Arithmetic: per-channel median and outer sum, then the divide by ten.
    hmmf_calc u_calc (
        .clk        (clk),
        .rst_n      (rst_n),
        .snap_valid (snap_valid),
        .snap_ready (snap_ready),
        .snap       (snap),
        .pix_out    (pix_out)
    );

endmodule

@@ verif/hmmf_result_check.sv @@
// Channel monitor for the 3x3 hybrid filter: predicts every filtered pixel and compares it.
module hmmf_result_check
    import hmmf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write_en,
    input  logic [ROW_LEN_W-1:0] cfg_write_data,
    hmmf_in_if                   pix_in,
    hmmf_out_if                  pix_out,
    output int                   error_count,
    output int                   results_due
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WIN_ROWS      = 3;
    localparam int BLEND_DIVISOR = 10;

    pixel_t               window [WIN_SIZE];
    int unsigned          fill_pos;
    int unsigned          col_count;
    logic [ROW_LEN_W-1:0] row_length;
    pixel_t               filtered_q [$];

    // Outer eight plus twice the median, divided by ten with truncation.
    function automatic logic [CHAN_W-1:0] blend_channel(input logic [CHAN_W-1:0] c [WIN_SIZE]);
        logic [CHAN_W-1:0] sorted [WIN_SIZE];
        logic [CHAN_W-1:0] x;
        int                j;
        int unsigned       acc;
        acc = 0;
        for (int i = 0; i < WIN_SIZE; i++)
        begin
            x = c[i];
            j = i;
            while (j > 0 && sorted[j-1] > x)
            begin
                sorted[j] = sorted[j-1];
                j--;
            end
            sorted[j] = x;
            if (i != WIN_CENTER)
            begin
                acc += c[i];
            end
        end
        acc += 2 * sorted[WIN_CENTER];
        return CHAN_W'(acc / BLEND_DIVISOR);
    endfunction

    function automatic pixel_t filter_window();
        logic [CHAN_W-1:0] r [WIN_SIZE];
        logic [CHAN_W-1:0] g [WIN_SIZE];
        logic [CHAN_W-1:0] b [WIN_SIZE];
        pixel_t            res;
        for (int i = 0; i < WIN_SIZE; i++)
        begin
            r[i] = window[i].red;
            g[i] = window[i].green;
            b[i] = window[i].blue;
        end
        res.red   = blend_channel(r);
        res.green = blend_channel(g);
        res.blue  = blend_channel(b);
        return res;
    endfunction

    // A length of zero or beyond the maximum behaves as the maximum.
    function automatic int unsigned row_limit();
        if (row_length == 0 || row_length > MAX_ROW_LENGTH)
        begin
            return MAX_ROW_LENGTH;
        end
        return row_length;
    endfunction

    task automatic take_pixel(input pixel_t pix);
        if (col_count == 0)
        begin
            if (fill_pos >= WIN_SIZE)
            begin
                fill_pos = 0;
            end
            window[fill_pos] = pix;
            fill_pos++;
            if (fill_pos < WIN_SIZE)
            begin
                return;
            end
        end
        else
        begin
            if (fill_pos >= WIN_ROWS)
            begin
                fill_pos = 0;
            end
            window[fill_pos * WIN_ROWS + 2] = pix;
            fill_pos++;
            if (fill_pos < WIN_ROWS)
            begin
                return;
            end
        end
        fill_pos = 0;
        filtered_q.push_back(filter_window());
        if (col_count + 1 >= row_limit())
        begin
            col_count = 0;
        end
        else
        begin
            col_count++;
            for (int r = 0; r < WIN_ROWS; r++)
            begin
                window[WIN_ROWS * r]     = window[WIN_ROWS * r + 1];
                window[WIN_ROWS * r + 1] = window[WIN_ROWS * r + 2];
            end
        end
    endtask

    // Every failure prints one line and is counted.
    task automatic report_mismatch(input string what);
        $display("%0t result_check: %s", $time, what);
        error_count++;
    endtask

    task automatic check_result(input pixel_t got);
        pixel_t want;
        if (filtered_q.size() == 0)
        begin
            report_mismatch($sformatf("result %h with none outstanding", got));
            return;
        end
        want = filtered_q.pop_front();
        if (got.red !== want.red)
        begin
            report_mismatch($sformatf("out_red %0d, predicted %0d", got.red, want.red));
        end
        if (got.green !== want.green)
        begin
            report_mismatch($sformatf("out_green %0d, predicted %0d", got.green, want.green));
        end
        if (got.blue !== want.blue)
        begin
            report_mismatch($sformatf("out_blue %0d, predicted %0d", got.blue, want.blue));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WIN_SIZE; i++)
            begin
                window[i] = '0;
            end
            fill_pos   = 0;
            col_count  = 0;
            row_length = ROW_LENGTH_RESET;
            filtered_q.delete();
            results_due = 0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                row_length = cfg_write_data;
            end
            if (pix_in.valid && pix_in.ready)
            begin
                take_pixel(pixel_t'({pix_in.blue, pix_in.green, pix_in.red}));
            end
            if (pix_out.valid && pix_out.ready)
            begin
                check_result(pixel_t'({pix_out.out_blue, pix_out.out_green, pix_out.out_red}));
            end
            results_due = filtered_q.size();
        end
    end

endmodule

@@ verif/tb_hybrid_median_mean_filter_3x3.sv @@
// Top of the 3x3 hybrid filter testbench: clock, reset, pixel stimulus and the verdict.
module tb_hybrid_median_mean_filter_3x3;
    timeunit 1ns;
    timeprecision 1ps;

    import hmmf_pkg::*;

    // This limit is far above the slowest legal run.
    localparam int CYCLE_LIMIT  = 300000;
    // Three pipeline stages sit between a pixel transfer and its result; allow margin.
    localparam int DRAIN_CYCLES = 8;
    localparam int BIG_ROW      = 1000;
    localparam int ITEMS_SHORT  = 180;
    localparam int ITEMS_LONG   = 60;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_write_en;
    logic [ROW_LEN_W-1:0] cfg_write_data;
    int                   send_idle_pct = 0;
    int                   out_stall_pct = 0;
    int                   mismatches;
    int                   results_due;
    int                   cycle_count = 0;
    int                   phase_items;
    logic [CHAN_W-1:0]    scene_level = 8'h80;
    logic [ROW_LEN_W-1:0] next_length;

    // Row lengths for the random phases: short rows, the single-window row, the
    // maximum, reset length, and values folding to it (zero, just past it, all ones).
    logic [ROW_LEN_W-1:0] phase_lengths [11] = '{13'd2, 13'd0, 13'd3, 13'd8191, 13'd1,
                                                 13'd4097, 13'd5, 13'd4096, 13'd4,
                                                 13'd256, 13'd7};

    hmmf_in_if  pix_in();
    hmmf_out_if pix_out();

    hybrid_median_mean_filter_3x3 dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .pix_in         (pix_in),
        .pix_out        (pix_out)
    );

    hmmf_result_check result_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .pix_in         (pix_in),
        .pix_out        (pix_out),
        .error_count    (mismatches),
        .results_due    (results_due)
    );

    always #5 clk = ~clk;

    // The result side stalls at random, at a rate chosen per phase.
    always @(posedge clk)
    begin
        pix_out.ready <= ($urandom_range(99) >= out_stall_pct);
    end

    // Watchdog: a hung handshake or a missing result ends the run here.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_hybrid_median_mean_filter_3x3: done, errors");
        $finish;
    end

    task automatic set_idling(input idle_mode_e mode);
        case (mode)
            IDLE_NONE:
            begin
                send_idle_pct = 0;
                out_stall_pct = 0;
            end
            IDLE_SENDER:
            begin
                send_idle_pct = 47;
                out_stall_pct = 0;
            end
            IDLE_RECEIVER:
            begin
                send_idle_pct = 0;
                out_stall_pct = 47;
            end
            default:
            begin
                send_idle_pct = 37;
                out_stall_pct = 37;
            end
        endcase
    endtask

    // Offers one pixel and returns in the step right after its transfer. Valid is
    // left high, so back-to-back pixels never see it dropped and raised at once.
    // Idle cycles put junk on the data lines with valid low.
    task automatic push_pixel(input logic [CHAN_W-1:0] r, g, b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            pix_in.valid <= 1'b0;
            pix_in.red   <= CHAN_W'($urandom_range(255));
            pix_in.green <= CHAN_W'($urandom_range(255));
            pix_in.blue  <= CHAN_W'($urandom_range(255));
            @(posedge clk);
        end
        pix_in.valid <= 1'b1;
        pix_in.red   <= r;
        pix_in.green <= g;
        pix_in.blue  <= b;
        @(posedge clk);
        while (!pix_in.ready)
        begin
            @(posedge clk);
        end
    endtask

    // Stops offering pixels, waits for every predicted result to be transferred,
    // then lets the pipeline settle. A half-filled window may stay behind; it holds
    // no result in flight.
    task automatic drain_block();
        pix_in.valid <= 1'b0;
        @(posedge clk);
        while (results_due != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_row_length(input logic [ROW_LEN_W-1:0] len);
        drain_block();
        cfg_write_en   <= 1'b1;
        cfg_write_data <= len;
        @(posedge clk);
        cfg_write_en   <= 1'b0;
    endtask

    // Channel values: mostly uniform, with rails and clusters around a drifting
    // level so that the median often lands among near-equal neighbors.
    function automatic logic [CHAN_W-1:0] pick_level();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            2, 3:    return CHAN_W'(scene_level + $urandom_range(6) - 3);
            default: return CHAN_W'($urandom_range(255));
        endcase
    endfunction

    initial
    begin
        rst_n          <= 1'b0;
        cfg_write_en   <= 1'b0;
        cfg_write_data <= '0;
        pix_in.valid   <= 1'b0;
        pix_in.red     <= '0;
        pix_in.green   <= '0;
        pix_in.blue    <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, reset row length. A first full window with red at the top
        // rail, green at zero and a blue ramp; then one column load.
        for (int i = 0; i < WIN_SIZE; i++)
        begin
            push_pixel(8'hFF, 8'h00, CHAN_W'(255 - 30 * i));
        end
        push_pixel(8'h00, 8'hFF, 8'h80);
        push_pixel(8'h01, 8'hFE, 8'h7F);
        push_pixel(8'hAA, 8'h55, 8'h0F);

        // Shrink the row to one output while two are already done in this row:
        // the next column window must close the row, and from then on every
        // window is a full nine-pixel load.
        write_row_length(13'd1);
        push_pixel(8'h55, 8'hAA, 8'hF0);
        push_pixel(8'h00, 8'hFF, 8'h00);
        push_pixel(8'hFF, 8'h00, 8'hFF);
        for (int i = 0; i < WIN_SIZE; i++)
        begin
            push_pixel((i % 2) ? 8'hFF : 8'h00, CHAN_W'(29 * i), 8'h80 ^ CHAN_W'(i));
        end

        // Random phases. Each writes a new row length while the block is idle and
        // picks an idling pattern; rows of zero or of BIG_ROW and more get fewer
        // pixels since they never wrap within a phase anyway.
        for (int p = 0; p <= 11; p++)
        begin
            next_length = (p < 11) ? phase_lengths[p] : ROW_LEN_W'($urandom_range(12, 1));
            write_row_length(next_length);
            set_idling(idle_mode_e'(p % 4));
            phase_items = (next_length == 0 || next_length >= BIG_ROW) ? ITEMS_LONG
                                                                       : ITEMS_SHORT;
            repeat (phase_items)
            begin
                if ($urandom_range(15) == 0)
                begin
                    scene_level = CHAN_W'($urandom_range(255));
                end
                push_pixel(pick_level(), pick_level(), pick_level());
            end
        end

        drain_block();
        if (mismatches == 0)
        begin
            $display("tb_hybrid_median_mean_filter_3x3: done, clean");
        end
        else
        begin
            $display("tb_hybrid_median_mean_filter_3x3: done, errors");
        end
        $finish;
    end

endmodule
